>>> design/scanline_packbits_decoder_macros.svh
// assertion macros used by the decoder
`ifndef SCANLINE_PACKBITS_DECODER_MACROS_SVH
`define SCANLINE_PACKBITS_DECODER_MACROS_SVH
`ifndef ASSERT_OFF
// property checked at every rising clock edge outside reset
`define SPD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// consequent checked in the cycle after the antecedent
`define SPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SPD_ASSERT(lbl, clk, rstn, prop, msg)
`define SPD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

>>> design/spd_pkg.sv
package spd_pkg;

  // field widths
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_W       = 15;
  localparam int unsigned ROW_W       = 14;
  localparam int unsigned LEN_W       = 15;
  localparam int unsigned CONS_W      = 17;
  localparam int unsigned OUT_TDATA_W = 32;

  // default store depth
  localparam int unsigned MAX_LINES_DEF = 16384;

  // reset value of the line count register
  localparam logic [CFG_W-1:0] LINE_COUNT_RST = 15'd1;

  // count byte that does nothing
  localparam logic [BYTE_W-1:0] NOOP_CODE = 8'h80;

  // decoder phase
  typedef enum logic [2:0] {
    PH_TABLE_HI,
    PH_TABLE_LO,
    PH_COUNT,
    PH_LITERAL,
    PH_REPEAT
  } phase_e;

  // one pixel run as it leaves the block
  typedef struct packed {
    logic [BYTE_W-1:0] pixel_value;
    logic [BYTE_W-1:0] run_length;
    logic [ROW_W-1:0]  row_index;
    logic              image_end;
  } res_t;

endpackage

>>> design/spd_ram.sv
module spd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/scanline_packbits_decoder.sv
// channel   dir  handshake                  payload
// s_axis    in   s_axis_tvalid/tready       tdata[7:0] in_byte
// m_axis    out  m_axis_tvalid/tready       tdata pixel_value, run_length, row_index;
//                                           tlast image_end
// cfg       in   cfg_valid/cfg_ready        cfg_data[14:0] line_count
//
// one byte per cycle unless m_axis stalls; its run, if any, goes to the output register
// the line table is stored compacted (non-empty lines only), so decoding skips empty lines
// the next line entry is prefetched from the store, so a line may end on every byte
// rst_ni clears all control state; the line store needs no clearing pass
// a stall on m_axis holds s_axis off only while the single output register is full
`include "scanline_packbits_decoder_macros.svh"
module scanline_packbits_decoder #(
  parameter int unsigned MAX_LINES = spd_pkg::MAX_LINES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [spd_pkg::BYTE_W-1:0]      s_axis_tdata_i,   // [7:0] in_byte
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [7:0] pixel_value, [15:8] run_length, [29:16] row_index, [31:30] zero
  output logic [spd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                            m_axis_tlast_o,   // image_end
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [spd_pkg::CFG_W-1:0]       cfg_data_i        // [14:0] line_count
);

  import spd_pkg::*;

  localparam int unsigned AW    = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_LINES + 1);
  localparam int unsigned ENT_W = AW + LEN_W;

  // state
  phase_e              phase_q, phase_d;
  logic [CFG_W-1:0]    line_count_q, line_count_d;
  logic [BYTE_W-1:0]   pend_q, pend_d;
  logic [CNT_W-1:0]    tab_pos_q, tab_pos_d;
  logic [CNT_W-1:0]    nz_cnt_q, nz_cnt_d;
  logic [CNT_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [ENT_W-1:0]    cur_q, cur_d;
  logic [CONS_W-1:0]   cons_q, cons_d;
  logic [BYTE_W-1:0]   lit_q, lit_d;
  logic [BYTE_W-1:0]   rep_q, rep_d;
  logic                byp_vld_q, byp_vld_d;
  logic [ENT_W-1:0]    byp_q;
  logic                out_vld_q, out_vld_d;
  res_t                out_q, out_d;

  // combinational helpers
  logic              acc_in, cfg_acc;
  logic [BYTE_W-1:0] in_b;
  logic [16:0]       lc_w, max_w, eff_w;
  logic [CNT_W-1:0]  eff, tab_pos_inc, nz_inc;
  logic [15:0]       tab_len;
  logic              tab_nz, tab_last;
  logic [CONS_W-1:0] cons_inc;
  logic              line_done, img_done, tok_end, finish, restart;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [ENT_W-1:0]  ram_wdata, ram_rdata, next_ent;
  logic              emit;
  res_t              res;

  assign in_b    = s_axis_tdata_i;
  assign acc_in  = s_axis_tvalid_i & s_axis_tready_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_acc = cfg_valid_i;

  // effective line count: zero reads as one, clipped to the store depth
  always_comb begin
    lc_w  = 17'(line_count_q);
    max_w = 17'(MAX_LINES);
    if (lc_w == '0) begin
      eff_w = 17'd1;
    end else if (lc_w > max_w) begin
      eff_w = max_w;
    end else begin
      eff_w = lc_w;
    end
    eff = CNT_W'(eff_w);
  end

  // table entry decode
  assign tab_len     = {pend_q, in_b};
  assign tab_nz      = !pend_q[7] && (tab_len != '0);
  assign tab_pos_inc = tab_pos_q + 1'b1;
  assign tab_last    = (tab_pos_inc == eff);
  assign ram_we      = acc_in && (phase_q == PH_TABLE_LO) && tab_nz;
  assign nz_inc      = nz_cnt_q + CNT_W'(ram_we);
  assign ram_waddr   = nz_cnt_q[AW-1:0];
  assign ram_wdata   = {tab_pos_q[AW-1:0], tab_len[LEN_W-1:0]};

  // token boundary and line end
  assign cons_inc  = cons_q + 1'b1;
  assign line_done = (cons_inc >= CONS_W'(cur_q[LEN_W-1:0]));
  assign img_done  = (rd_ptr_q == nz_cnt_q);
  always_comb begin
    case (phase_q)
      PH_COUNT:   tok_end = (in_b == NOOP_CODE);
      PH_LITERAL: tok_end = (lit_q == 8'd1);
      PH_REPEAT:  tok_end = 1'b1;
      default:    tok_end = 1'b0;
    endcase
  end

  assign finish = acc_in &&
                  ((phase_q == PH_TABLE_LO && tab_last && nz_inc == '0) ||
                   (tok_end && line_done && img_done));
  assign restart = cfg_acc || finish;

  // next entry: the store, or the entry written at the edge it was read
  assign ram_raddr = rd_ptr_d[AW-1:0];
  assign byp_vld_d = ram_we && (ram_waddr == ram_raddr);
  assign next_ent  = byp_vld_q ? byp_q : ram_rdata;

  spd_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_LINES)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_TABLE_HI: begin
        if (acc_in) phase_d = PH_TABLE_LO;
      end
      PH_TABLE_LO: begin
        if (acc_in) begin
          if (tab_last && nz_inc != '0) phase_d = PH_COUNT;
          else                          phase_d = PH_TABLE_HI;
        end
      end
      PH_COUNT: begin
        if (acc_in) begin
          if (!in_b[7])         phase_d = PH_LITERAL;
          else if (!tok_end)    phase_d = PH_REPEAT;
          else                  phase_d = PH_COUNT;
        end
      end
      PH_LITERAL: begin
        if (acc_in && tok_end) phase_d = PH_COUNT;
      end
      PH_REPEAT: begin
        if (acc_in) phase_d = PH_COUNT;
      end
      default: phase_d = PH_TABLE_HI;
    endcase
    if (restart) phase_d = PH_TABLE_HI;
  end

  // datapath and result
  always_comb begin
    line_count_d = cfg_acc ? cfg_data_i : line_count_q;
    pend_d    = pend_q;
    tab_pos_d = tab_pos_q;
    nz_cnt_d  = nz_cnt_q;
    rd_ptr_d  = rd_ptr_q;
    cur_d     = cur_q;
    cons_d    = cons_q;
    lit_d     = lit_q;
    rep_d     = rep_q;
    emit      = 1'b0;
    res.pixel_value = in_b;
    res.run_length  = 8'd1;
    res.row_index   = ROW_W'(cur_q[ENT_W-1:LEN_W]);
    res.image_end   = 1'b0;

    case (phase_q)
      PH_TABLE_HI: begin
        if (acc_in) pend_d = in_b;
      end
      PH_TABLE_LO: begin
        if (acc_in) begin
          tab_pos_d = tab_pos_inc;
          nz_cnt_d  = nz_inc;
          if (ram_we && nz_cnt_q == '0) cur_d = ram_wdata;
          if (tab_last) begin
            tab_pos_d = '0;
            cons_d    = '0;
            rd_ptr_d  = CNT_W'(1);
            if (nz_inc == '0) begin
              emit            = 1'b1;
              res.pixel_value = '0;
              res.run_length  = '0;
              res.row_index   = ROW_W'(eff - 1'b1);
              res.image_end   = 1'b1;
            end
          end
        end
      end
      PH_COUNT: begin
        if (acc_in) begin
          cons_d = cons_inc;
          if (!in_b[7])     lit_d = in_b + 1'b1;
          else if (!tok_end) rep_d = BYTE_W'(9'd257 - {1'b0, in_b});
        end
      end
      PH_LITERAL: begin
        if (acc_in) begin
          cons_d = cons_inc;
          emit   = 1'b1;
          lit_d  = lit_q - 1'b1;
        end
      end
      PH_REPEAT: begin
        if (acc_in) begin
          cons_d         = cons_inc;
          emit           = 1'b1;
          res.run_length = rep_q;
          rep_d          = '0;
        end
      end
      default: ;
    endcase

    // line end at a token boundary
    if (acc_in && tok_end && line_done) begin
      cons_d = '0;
      if (img_done) begin
        if (emit) begin
          res.image_end = 1'b1;
        end else begin
          emit            = 1'b1;
          res.pixel_value = '0;
          res.run_length  = '0;
          res.row_index   = ROW_W'(eff - 1'b1);
          res.image_end   = 1'b1;
        end
      end else begin
        cur_d    = next_ent;
        rd_ptr_d = rd_ptr_q + 1'b1;
      end
    end

    // back to the start of a table
    if (restart) begin
      tab_pos_d = '0;
      nz_cnt_d  = '0;
      rd_ptr_d  = '0;
      cons_d    = '0;
      lit_d     = '0;
      rep_d     = '0;
    end
  end

  // output register
  assign s_axis_tready_o = !out_vld_q || m_axis_tready_i;
  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (acc_in && emit) begin
      out_vld_d = 1'b1;
      out_d     = res;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {2'b00, out_q.row_index, out_q.run_length, out_q.pixel_value};
  assign m_axis_tlast_o  = out_q.image_end;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_TABLE_HI;
      line_count_q <= LINE_COUNT_RST;
      tab_pos_q    <= '0;
      nz_cnt_q     <= '0;
      rd_ptr_q     <= '0;
      cons_q       <= '0;
      lit_q        <= '0;
      rep_q        <= '0;
      byp_vld_q    <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      line_count_q <= line_count_d;
      tab_pos_q    <= tab_pos_d;
      nz_cnt_q     <= nz_cnt_d;
      rd_ptr_q     <= rd_ptr_d;
      cons_q       <= cons_d;
      lit_q        <= lit_d;
      rep_q        <= rep_d;
      byp_vld_q    <= byp_vld_d;
      out_vld_q    <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    cur_q  <= cur_d;
    byp_q  <= ram_wdata;
    out_q  <= out_d;
  end

  // checks
  `SPD_ASSERT(a_ptr_bound, clk_i, rst_ni, (phase_q == PH_COUNT || phase_q == PH_LITERAL || phase_q == PH_REPEAT) |-> (nz_cnt_q != '0 && rd_ptr_q <= nz_cnt_q), "line pointer beyond stored lines")
  `SPD_ASSERT_NEXT(a_table_done, clk_i, rst_ni, acc_in && !cfg_acc && phase_q == PH_TABLE_LO && tab_last && nz_inc != '0, phase_q == PH_COUNT && rd_ptr_q == CNT_W'(1), "decode did not start after table")
  `SPD_ASSERT(a_marker_end, clk_i, rst_ni, (m_axis_tvalid_o && out_q.run_length == '0) |-> out_q.image_end, "empty run without image end")

endmodule
